// ----- src/uartfpd_pkg.sv -----
`timescale 1ns / 1ps

package uartfpd_pkg;

    // Most results that one frame can produce.
    localparam int MAX_RESULTS = 32;

    // Width of the emitted subscriber mask and number of command bytes in the table.
    localparam int MASK_W      = 4;
    localparam int TABLE_BYTES = 8;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEAD = 2'd0;
    localparam logic [1:0] CFG_TAIL = 2'd1;
    localparam logic [1:0] CFG_CMDS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_frame;
        logic store_byte;
        logic load_single;
        logic start_emit;
        logic rd_issue;
        logic load_payload;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_hit;
        logic tail_hit;
        logic single;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/uart_frame_parser_dispatch.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+---------------------------------------------
// input     | in        | i_in_valid, o_in_stall | i_data_byte
// result    | out       | o_out_valid, i_out_stall | o_status, o_command, o_payload_byte,
//           |           |                        | o_has_data, o_subscriber_mask, o_last
// config    | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A tail of a bad or empty frame loads its single result in the same cycle. A good frame then
// emits its payload byte by byte, each first read from the frame store and then loaded into the
// output register, and input is held off meanwhile.
// Reset is synchronous and active low; it returns the parser to hunting and clears the
// configuration to its defaults, while the frame store itself is not cleared.
// A stalled result holds in the output register; input is stalled while that register is full and not taken.

module uart_frame_parser_dispatch #(
    parameter int FRAME_DEPTH         = 32,
    parameter int NUM_SUBSCRIBERS     = 4,
    parameter int CMDS_PER_SUBSCRIBER = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Received byte channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_command,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_data,
    output logic [3:0]  o_subscriber_mask,
    output logic        o_last
);
    import uartfpd_pkg::*;

    // The controller sequences the frame: hunting, collecting, and the read then load loop
    // that walks the payload out of the frame store. The datapath owns every register but the state.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    uartfpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath keeps a running sum of the stored bytes, so the checksum is ready as soon
    // as the tail transaction arrives, without a pass over the frame store.
    uartfpd_dp #(
        .FRAME_DEPTH         (FRAME_DEPTH),
        .NUM_SUBSCRIBERS     (NUM_SUBSCRIBERS),
        .CMDS_PER_SUBSCRIBER (CMDS_PER_SUBSCRIBER)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_data_byte       (i_data_byte),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_command         (o_command),
        .o_payload_byte    (o_payload_byte),
        .o_has_data        (o_has_data),
        .o_subscriber_mask (o_subscriber_mask),
        .o_last            (o_last)
    );

endmodule

// ----- src/uartfpd_ctrl.sv -----
`timescale 1ns / 1ps

module uartfpd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  uartfpd_pkg::t_dp_stat i_stat,
    output uartfpd_pkg::t_dp_cmd  o_cmd,
    output logic                  o_in_stall
);
    import uartfpd_pkg::*;

    localparam logic [1:0] S_HUNT    = 2'd0;
    localparam logic [1:0] S_COLLECT = 2'd1;
    localparam logic [1:0] S_READ    = 2'd2;
    localparam logic [1:0] S_LOAD    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_in_ok;
    logic       w_in_fire;

    // Bytes are taken only while framing and while the output register can take a result.
    assign w_in_ok    = ((r_state == S_HUNT) || (r_state == S_COLLECT)) && i_stat.out_free;
    assign w_in_fire  = i_in_valid && w_in_ok;
    assign o_in_stall = !w_in_ok;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (w_in_fire && i_stat.head_hit) begin
                    o_cmd.clear_frame = 1'b1;
                    n_state           = S_COLLECT;
                end
            end
            S_COLLECT: begin
                if (w_in_fire) begin
                    if (i_stat.tail_hit) begin
                        if (i_stat.single) begin
                            o_cmd.load_single = 1'b1;
                            n_state           = S_HUNT;
                        end else begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = S_READ;
                        end
                    end else begin
                        o_cmd.store_byte = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_payload = 1'b1;
                    n_state            = i_stat.emit_last ? S_HUNT : S_READ;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/uartfpd_dp.sv -----
`timescale 1ns / 1ps

module uartfpd_dp #(
    parameter int FRAME_DEPTH         = 32,
    parameter int NUM_SUBSCRIBERS     = 4,
    parameter int CMDS_PER_SUBSCRIBER = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uartfpd_pkg::t_dp_cmd  i_cmd,
    output uartfpd_pkg::t_dp_stat o_stat,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [7:0]            o_command,
    output logic [7:0]            o_payload_byte,
    output logic                  o_has_data,
    output logic [3:0]            o_subscriber_mask,
    output logic                  o_last
);
    import uartfpd_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int SW = $clog2(FRAME_DEPTH * 255 + 1);
    localparam int LW = $clog2(MAX_RESULTS + 1);

    // Configuration registers.
    logic [7:0]    r_head;
    logic [7:0]    r_tail;
    logic [63:0]   r_cmds;

    // Frame state.
    logic [7:0]    r_mem [FRAME_DEPTH];
    logic [CW-1:0] r_count;
    logic          r_overflow;
    logic [SW-1:0] r_sum_all;
    logic [SW-1:0] r_sum_prev;
    logic [7:0]    r_last_byte;
    logic [7:0]    r_cmd_byte;
    logic [7:0]    r_len_byte;

    // Emission state.
    logic [LW-1:0] r_idx;
    logic [LW-1:0] r_eff_len;
    logic [7:0]    r_rd_data;

    // Output register.
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [7:0]    r_command;
    logic [7:0]    r_payload;
    logic          r_has_data;
    logic [3:0]    r_mask;
    logic          r_last;

    logic          w_out_fire;
    logic          w_full;
    logic          w_short;
    logic          w_sum_ok;
    logic [1:0]    w_err_status;
    logic          w_err;
    logic [CW-1:0] w_avail;
    logic [8:0]    w_len_a;
    logic [8:0]    w_len_b;
    logic [LW-1:0] w_eff_len;
    logic [3:0]    w_mask;
    logic [LW:0]   w_addr_full;
    logic [LW-1:0] w_idx_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 8'hAA;
            r_tail <= 8'h55;
            r_cmds <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAD: r_head <= i_cfg_data[7:0];
                CFG_TAIL: r_tail <= i_cfg_data[7:0];
                CFG_CMDS: r_cmds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Subscriber match: subscribers past the mask width and slots past the table drop out.
    always_comb begin
        int slot;
        w_mask = '0;
        for (int s = 0; s < MASK_W; s++) begin
            for (int j = 0; j < 4; j++) begin
                slot = s * CMDS_PER_SUBSCRIBER + j;
                if ((s < NUM_SUBSCRIBERS) && (j < CMDS_PER_SUBSCRIBER)
                    && (slot < TABLE_BYTES)) begin
                    if (r_cmds[8 * (slot % TABLE_BYTES) +: 8] == r_cmd_byte) begin
                        w_mask[s] = 1'b1;
                    end
                end
            end
        end
    end

    assign w_out_fire = r_out_valid && !i_out_stall;
    assign w_full     = (r_count == CW'(FRAME_DEPTH));
    assign w_short    = (r_count < CW'(3));
    assign w_sum_ok   = (r_sum_prev == SW'(r_last_byte));
    assign w_err      = r_overflow || w_short || !w_sum_ok;

    always_comb begin
        if (r_overflow) begin
            w_err_status = ST_OVERFLOW;
        end else if (w_short) begin
            w_err_status = ST_SHORT;
        end else begin
            w_err_status = ST_CHECKSUM;
        end
    end

    // Payload length is cut to the stored bytes between LEN and CHK and to the result limit.
    assign w_avail   = r_count - CW'(3);
    assign w_len_a   = (9'(w_avail) < {1'b0, r_len_byte}) ? 9'(w_avail) : {1'b0, r_len_byte};
    assign w_len_b   = (w_len_a < 9'(MAX_RESULTS)) ? w_len_a : 9'(MAX_RESULTS);
    assign w_eff_len = w_len_b[LW-1:0];

    assign w_idx_next  = r_idx + LW'(1);
    assign w_addr_full = {1'b0, r_idx} + (LW + 1)'(2);

    assign o_stat.head_hit  = (i_data_byte == r_head);
    assign o_stat.tail_hit  = (i_data_byte == r_tail);
    assign o_stat.single    = w_err || (w_eff_len == '0);
    assign o_stat.emit_last = (w_idx_next == r_eff_len);
    assign o_stat.out_free  = !r_out_valid || w_out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_sum_all  <= '0;
            r_sum_prev <= '0;
        end else if (i_cmd.clear_frame) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_sum_all  <= '0;
            r_sum_prev <= '0;
        end else if (i_cmd.store_byte) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count    <= r_count + CW'(1);
                r_sum_prev <= r_sum_all;
                r_sum_all  <= r_sum_all + SW'(i_data_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_data_byte;
            r_last_byte            <= i_data_byte;
            if (r_count == CW'(0)) begin
                r_cmd_byte <= i_data_byte;
            end
            if (r_count == CW'(1)) begin
                r_len_byte <= i_data_byte;
            end
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[w_addr_full[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_idx     <= '0;
            r_eff_len <= w_eff_len;
        end else if (i_cmd.load_payload) begin
            r_idx <= w_idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_payload) begin
            r_out_valid <= 1'b1;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_status   <= w_err ? w_err_status : ST_OK;
            r_command  <= (r_count == CW'(0)) ? 8'd0 : r_cmd_byte;
            r_payload  <= 8'd0;
            r_has_data <= 1'b0;
            r_mask     <= w_err ? 4'd0 : w_mask;
            r_last     <= 1'b1;
        end else if (i_cmd.load_payload) begin
            r_status   <= ST_OK;
            r_command  <= r_cmd_byte;
            r_payload  <= r_rd_data;
            r_has_data <= 1'b1;
            r_mask     <= w_mask;
            r_last     <= o_stat.emit_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_command         = r_command;
    assign o_payload_byte    = r_payload;
    assign o_has_data        = r_has_data;
    assign o_subscriber_mask = r_mask;
    assign o_last            = r_last;

endmodule
